@@ rtl/core/m4vt_pkg.sv @@
// Package for the 4x4 matrix-vector transform core.
// Holds the widths, register indexes, payload structs and pipeline control types.
// No dependencies; every other file of the core takes names from here by scope.
package m4vt_pkg;

    localparam int LANES         = 4;
    localparam int ELEM_W        = 32;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int SUM_W         = PROD_W + 2;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = $clog2(NUM_REGS);
    localparam int CFG_INDEX_W   = REG_IDX_W + 1;
    localparam int CFG_DATA_W    = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    localparam logic signed [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef logic signed [ELEM_W-1:0] q_t;
    typedef q_t [LANES-1:0] vec4_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] in_x;
        logic signed [ELEM_W-1:0] in_y;
        logic signed [ELEM_W-1:0] in_z;
        logic signed [ELEM_W-1:0] in_w;
    } in_item_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_x;
        logic signed [ELEM_W-1:0] out_y;
        logic signed [ELEM_W-1:0] out_z;
        logic signed [ELEM_W-1:0] out_w;
        logic                     saturated;
    } out_item_t;

    // Per-stage load enables, already qualified by the valid bit feeding each stage.
    typedef struct packed {
        logic en_mul;
        logic en_pair;
        logic en_out;
    } pipe_ctl_t;

    typedef struct packed {
        q_t   value;
        logic sat;
    } lane_res_t;

endpackage

@@ rtl/core/m4vt_lane.sv @@
// One row lane of the transform: four multipliers, a pair-sum stage and the final
// sum with floor shift and saturation. Depends on m4vt_pkg.
module m4vt_lane #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  m4vt_pkg::pipe_ctl_t ctl,
    input  m4vt_pkg::vec4_t    row,
    input  m4vt_pkg::vec4_t    vec,
    output m4vt_pkg::lane_res_t res
);

    localparam int LANES  = m4vt_pkg::LANES;
    localparam int PROD_W = m4vt_pkg::PROD_W;
    localparam int PAIR_W = m4vt_pkg::PAIR_W;
    localparam int SUM_W  = m4vt_pkg::SUM_W;
    localparam int ELEM_W = m4vt_pkg::ELEM_W;

    logic signed [PROD_W-1:0] prod_reg  [LANES];
    logic signed [PROD_W-1:0] prod_next [LANES];
    logic signed [PAIR_W-1:0] pair_reg  [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    logic                     in_range;

    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            prod_next[c] = PROD_W'($signed(row[c])) * PROD_W'($signed(vec[c]));
        end
        pair_next[0] = {prod_reg[0][PROD_W-1], prod_reg[0]}
                     + {prod_reg[1][PROD_W-1], prod_reg[1]};
        pair_next[1] = {prod_reg[2][PROD_W-1], prod_reg[2]}
                     + {prod_reg[3][PROD_W-1], prod_reg[3]};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (ctl.en_pair)
        begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
    end

    // Exact sum, then an arithmetic shift, which is a floor division by 2^FRAC_BITS.
    always_comb
    begin
        sum      = {pair_reg[0][PAIR_W-1], pair_reg[0]} + {pair_reg[1][PAIR_W-1], pair_reg[1]};
        shifted  = sum >>> FRAC_BITS;
        in_range = (&shifted[SUM_W-1:ELEM_W-1]) | ~(|shifted[SUM_W-1:ELEM_W-1]);
        if (in_range)
        begin
            res.value = shifted[ELEM_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            res.value = m4vt_pkg::Q_MIN;
        end
        else
        begin
            res.value = m4vt_pkg::Q_MAX;
        end
        res.sat = ~in_range;
    end

endmodule

@@ rtl/core/m4vt_merge.sv @@
// Merge stage of the transform: gathers the four lane results into one result
// item, combines the saturation flags and holds the output register. Depends on m4vt_pkg.
module m4vt_merge (
    input  logic                  clk,
    input  m4vt_pkg::pipe_ctl_t   ctl,
    input  m4vt_pkg::lane_res_t   lane_res [m4vt_pkg::LANES],
    output m4vt_pkg::out_item_t   item
);

    m4vt_pkg::out_item_t item_reg;
    m4vt_pkg::out_item_t item_next;

    always_comb
    begin
        item_next.out_x     = lane_res[0].value;
        item_next.out_y     = lane_res[1].value;
        item_next.out_z     = lane_res[2].value;
        item_next.out_w     = lane_res[3].value;
        item_next.saturated = lane_res[0].sat | lane_res[1].sat
                            | lane_res[2].sat | lane_res[3].sat;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_out)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

@@ rtl/core/matrix4_vector_transform_core.sv @@
// 4x4 matrix-vector transform core: an input transfer passes the multiply, pair-sum and
// output registers before its result is valid and can be transferred; throughput one
// vector per cycle while res_ready does not hold off the output, set by the four row lanes
// of four multipliers each working in parallel behind a three-stage elastic pipeline.
// Asynchronous active-low reset empties the pipeline and loads the identity matrix
// (1 << FRAC_BITS on the diagonal). Depends on m4vt_pkg, m4vt_lane and m4vt_merge.
module matrix4_vector_transform_core #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [m4vt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [m4vt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 vec_valid,
    output logic                                 vec_ready,
    input  m4vt_pkg::in_item_t                   vec_data,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output m4vt_pkg::out_item_t                  res_data
);

    localparam int LANES      = m4vt_pkg::LANES;
    localparam int NUM_REGS   = m4vt_pkg::NUM_REGS;
    localparam int REG_IDX_W  = m4vt_pkg::REG_IDX_W;
    localparam int ELEM_W     = m4vt_pkg::ELEM_W;
    localparam int CFG_DATA_W = m4vt_pkg::CFG_DATA_W;

    // Identity values: the diagonal element sits in the low word for even columns
    // and in the high word for odd columns.
    localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
    localparam logic [CFG_DATA_W-1:0] ONE_HI = ONE_LO << ELEM_W;

    // Matrix registers. The host must write them only while the core is idle; the core does
    // not enforce this itself, and the lanes read them directly without a shadow copy.
    logic [CFG_DATA_W-1:0] mat_reg [NUM_REGS];
    logic                  cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index < NUM_REGS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (i == int'(m4vt_pkg::REG_ROW0_COLS01) || i == int'(m4vt_pkg::REG_ROW2_COLS23))
                begin
                    mat_reg[REG_IDX_W'(i)] <= ONE_LO;
                end
                else if (i == int'(m4vt_pkg::REG_ROW1_COLS01)
                      || i == int'(m4vt_pkg::REG_ROW3_COLS23))
                begin
                    mat_reg[REG_IDX_W'(i)] <= ONE_HI;
                end
                else
                begin
                    mat_reg[REG_IDX_W'(i)] <= '0;
                end
            end
        end
        else if (cfg_hit)
        begin
            // Writes to indexes beyond the register list are accepted and dropped.
            mat_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Unpack the registers into rows of signed elements. Row r, column c lives in
    // register 2r + c/2, low word for even c and high word for odd c.
    m4vt_pkg::vec4_t row_elems [LANES];
    m4vt_pkg::vec4_t vec_elems;

    for (genvar r = 0; r < LANES; r++)
    begin : g_row
        for (genvar c = 0; c < LANES; c++)
        begin : g_col
            assign row_elems[r][c] = mat_reg[2 * r + c / 2][ELEM_W * (c % 2) +: ELEM_W];
        end
    end

    assign vec_elems[0] = vec_data.in_x;
    assign vec_elems[1] = vec_data.in_y;
    assign vec_elems[2] = vec_data.in_z;
    assign vec_elems[3] = vec_data.in_w;

    // Elastic pipeline control. Each stage takes a new transfer when it is empty or
    // when the stage after it moves on, so bubbles collapse and an input transfer is
    // still taken while a finished result waits at the output if an earlier stage is empty.
    logic v_mul_reg;
    logic v_pair_reg;
    logic v_out_reg;
    logic load_mul;
    logic load_pair;
    logic load_out;
    m4vt_pkg::pipe_ctl_t ctl;

    assign load_out  = !v_out_reg  || res_ready;
    assign load_pair = !v_pair_reg || load_out;
    assign load_mul  = !v_mul_reg  || load_pair;
    assign vec_ready = load_mul;

    assign ctl.en_mul  = load_mul  && vec_valid;
    assign ctl.en_pair = load_pair && v_mul_reg;
    assign ctl.en_out  = load_out  && v_pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_mul_reg  <= 1'b0;
            v_pair_reg <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            if (load_mul)
            begin
                v_mul_reg <= vec_valid;
            end
            if (load_pair)
            begin
                v_pair_reg <= v_mul_reg;
            end
            if (load_out)
            begin
                v_out_reg <= v_pair_reg;
            end
        end
    end

    // One lane per matrix row; the merge stage registers the combined result.
    m4vt_pkg::lane_res_t lane_res [LANES];

    for (genvar r = 0; r < LANES; r++)
    begin : g_lane
        m4vt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .ctl (ctl),
            .row (row_elems[r]),
            .vec (vec_elems),
            .res (lane_res[r])
        );
    end

    m4vt_merge u_merge (
        .clk      (clk),
        .ctl      (ctl),
        .lane_res (lane_res),
        .item     (res_data)
    );

    assign res_valid = v_out_reg;

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> vec_ready)
        else $error("input stalled while the output register is empty");

    // A result in the pair stage reaches the output once the output can take it.
    a_pair_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (v_pair_reg && (!res_valid || res_ready)) |=> res_valid)
        else $error("pair stage result did not advance to the output");

    // The saturation flag is only raised when some component sits at a rail.
    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.saturated) |->
            (res_data.out_x == m4vt_pkg::Q_MAX || res_data.out_x == m4vt_pkg::Q_MIN ||
             res_data.out_y == m4vt_pkg::Q_MAX || res_data.out_y == m4vt_pkg::Q_MIN ||
             res_data.out_z == m4vt_pkg::Q_MAX || res_data.out_z == m4vt_pkg::Q_MIN ||
             res_data.out_w == m4vt_pkg::Q_MAX || res_data.out_w == m4vt_pkg::Q_MIN))
        else $error("saturated flag set with no clamped component");

    // A configuration transfer to row 0 updates the column 0 element the lane sees.
    a_cfg_reaches_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == m4vt_pkg::CFG_INDEX_W'(m4vt_pkg::REG_ROW0_COLS01)) |=>
            (row_elems[0][0] == $past(cfg_data[ELEM_W-1:0])))
        else $error("configuration write did not reach the row 0 lane");

endmodule

@@ tb/sv/matrix4_vector_transform_core_test.sv @@
// Self-checking testbench for matrix4_vector_transform_core: streams Q16.16 vectors
// through the 4x4 matrix product and checks every result against a bench-side model.
// Depends on m4vt_pkg for the payload structs and constants, and on the core RTL.
module matrix4_vector_transform_core_test;

    import m4vt_pkg::*;

    // The core has three pipeline stages between an input transfer and its result.
    localparam int PIPE_LATENCY    = 3;
    localparam int FRAC            = FRAC_BITS_DEF;
    // Longest stretch without any transfer before the run is declared hung. The
    // deliberate receiver hold-off below is far shorter than this.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 110;
    localparam int PRESSURE_ITEMS  = 40;

    localparam q_t ONE_Q  = q_t'(1 << FRAC);
    localparam q_t HALF_Q = q_t'(1 << (FRAC - 1));

    // How the result side paces its ready signal.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_e;

    // Value families for matrix elements and vector components.
    typedef enum logic [1:0] {
        VAL_FULL,
        VAL_SMALL,
        VAL_EXTREME,
        VAL_MIXED
    } val_kind_e;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic        vec_valid;
    logic        vec_ready;
    in_item_t    vec_data;
    logic        res_valid;
    logic        res_ready;
    out_item_t   res_data;

    // Bench copy of the eight matrix registers, updated on each accepted write to a register index.
    logic [CFG_DATA_W-1:0] coef_regs [NUM_REGS];
    // Predicted results, oldest first, waiting for the matching output transfer.
    out_item_t   pending_results [$];

    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          hold_left   = 0;
    bit          tx_gaps     = 1'b0;
    rx_mode_e    rx_mode     = RX_ALWAYS;

    matrix4_vector_transform_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .vec_data  (vec_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // After reset the core holds the identity matrix: one on the diagonal.
    function automatic void load_identity_model();
        for (int i = 0; i < NUM_REGS; i++)
            coef_regs[i] = '0;
        coef_regs[REG_ROW0_COLS01] = CFG_DATA_W'(ONE_Q);
        coef_regs[REG_ROW1_COLS01] = {ONE_Q, q_t'(0)};
        coef_regs[REG_ROW2_COLS23] = CFG_DATA_W'(ONE_Q);
        coef_regs[REG_ROW3_COLS23] = {ONE_Q, q_t'(0)};
    endfunction

    // Each row is an exact sum of four 64-bit products. A 68-bit accumulator
    // cannot overflow, so an arithmetic shift gives the floor directly, and the
    // clamp to the 32-bit range happens only after the shift.
    function automatic out_item_t transform_vector(input in_item_t item);
        q_t                 vin  [LANES];
        q_t                 lane [LANES];
        logic signed [67:0] coef;
        logic signed [67:0] comp;
        logic signed [67:0] acc;
        logic signed [67:0] scaled;
        out_item_t          res;
        vin[0] = item.in_x;
        vin[1] = item.in_y;
        vin[2] = item.in_z;
        vin[3] = item.in_w;
        res.saturated = 1'b0;
        for (int r = 0; r < LANES; r++) begin
            acc = '0;
            for (int c = 0; c < LANES; c++) begin
                coef = q_t'(coef_regs[r * 2 + c / 2][(c % 2) * ELEM_W +: ELEM_W]);
                comp = vin[c];
                acc  = acc + coef * comp;
            end
            scaled = acc >>> FRAC;
            if (scaled > Q_MAX) begin
                lane[r]       = Q_MAX;
                res.saturated = 1'b1;
            end else if (scaled < Q_MIN) begin
                lane[r]       = Q_MIN;
                res.saturated = 1'b1;
            end else begin
                lane[r] = q_t'(scaled);
            end
        end
        res.out_x = lane[0];
        res.out_y = lane[1];
        res.out_z = lane[2];
        res.out_w = lane[3];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic q_t pick_value(input val_kind_e kind);
        case (kind)
            VAL_FULL:  return q_t'($urandom());
            // Roughly plus or minus 4.0, so sums of products stay in range.
            VAL_SMALL: return q_t'($urandom_range(0, 32'h0008_0000)) - q_t'(32'h0004_0000);
            VAL_EXTREME: begin
                case ($urandom_range(0, 5))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return ONE_Q;
                    4:       return -ONE_Q;
                    default: return q_t'(-1);
                endcase
            end
            default:   return pick_value(val_kind_e'($urandom_range(0, 2)));
        endcase
    endfunction

    function automatic in_item_t mk_vec(input q_t x, input q_t y, input q_t z, input q_t w);
        in_item_t item;
        item.in_x = x;
        item.in_y = y;
        item.in_z = z;
        item.in_w = w;
        return item;
    endfunction

    function automatic in_item_t random_vec();
        val_kind_e kind;
        kind = ($urandom_range(0, 9) < 6) ? VAL_MIXED : VAL_SMALL;
        return mk_vec(pick_value(kind), pick_value(kind), pick_value(kind), pick_value(kind));
    endfunction

    // One register write transfer. Indexes past the last register are legal on
    // the port and must leave the matrix untouched.
    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_W'(idx);
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx < NUM_REGS)
            coef_regs[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(input val_kind_e kind);
        q_t lo;
        q_t hi;
        for (int i = 0; i < NUM_REGS; i++) begin
            lo = pick_value(kind);
            hi = pick_value(kind);
            write_reg(i, {hi, lo});
        end
    endtask

    task automatic load_uniform(input q_t elem);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(i, {elem, elem});
    endtask

    // Offers one vector and returns once it has been accepted. With gaps enabled
    // the sender works in bursts: when a burst runs out, valid drops for a random
    // number of cycles before the next one starts. Within a burst valid stays high
    // across back-to-back transfers and only the payload changes.
    task automatic send_vector(input in_item_t item);
        int gap;
        if (tx_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            vec_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        vec_valid <= 1'b1;
        vec_data  <= item;
        do @(posedge clk); while (!vec_ready);
        pending_results.push_back(transform_vector(item));
        if (burst_left > 0)
            burst_left--;
    endtask

    // Ends the current stream and waits for every predicted result to come out.
    // Every vector produces a result, so an empty queue means the core is idle.
    task automatic drain_results();
        @(negedge clk);
        vec_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset, with the identity matrix, every vector must come
    // back unchanged, including the full-scale corners.
    task automatic test_reset_identity();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        send_vector(mk_vec('0, '0, '0, '0));
        send_vector(mk_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_vector(mk_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_vector(mk_vec(q_t'(-1), q_t'(-1), q_t'(-1), q_t'(-1)));
        send_vector(mk_vec(ONE_Q, -ONE_Q, HALF_Q, q_t'(1)));
        send_vector(mk_vec(Q_MAX, Q_MIN, '0, q_t'(-1)));
        drain_results();
    endtask

    // Unit vectors read back one column each, which shows that every register
    // half lands on the right matrix element. Writes to the unused upper indexes
    // follow and must not disturb anything.
    task automatic test_register_map();
        rx_mode = RX_RANDOM;
        load_matrix(VAL_SMALL);
        send_vector(mk_vec(ONE_Q, '0, '0, '0));
        send_vector(mk_vec('0, ONE_Q, '0, '0));
        send_vector(mk_vec('0, '0, ONE_Q, '0));
        send_vector(mk_vec('0, '0, '0, ONE_Q));
        drain_results();
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(NUM_REGS + i, {$urandom(), $urandom()});
        send_vector(mk_vec(ONE_Q, ONE_Q, ONE_Q, ONE_Q));
        drain_results();
    endtask

    // Clamping in both directions, the exact boundary of the range, a sum of
    // four most-negative products that only fits in more than 64 bits, and
    // rounding of negative fractions toward minus infinity.
    task automatic test_saturation();
        rx_mode = RX_ALWAYS;
        load_uniform(Q_MAX);
        send_vector(mk_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_vector(mk_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        drain_results();
        load_uniform(Q_MIN);
        send_vector(mk_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_vector(mk_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        drain_results();
        load_uniform(ONE_Q);
        send_vector(mk_vec(Q_MAX, '0, '0, '0));
        send_vector(mk_vec(Q_MAX, q_t'(1), '0, '0));
        send_vector(mk_vec(Q_MIN, '0, '0, '0));
        send_vector(mk_vec(Q_MIN, q_t'(-1), '0, '0));
        drain_results();
        load_uniform(HALF_Q);
        send_vector(mk_vec(q_t'(1), '0, '0, '0));
        send_vector(mk_vec(q_t'(-1), '0, '0, '0));
        drain_results();
    endtask

    // A matrix-matrix product: the four columns of a second matrix go in as
    // four vectors, and the results are the columns of the product.
    task automatic test_matrix_product();
        q_t rhs [LANES][LANES];
        rx_mode = RX_PATTERN;
        load_matrix(VAL_SMALL);
        for (int r = 0; r < LANES; r++)
            for (int c = 0; c < LANES; c++)
                rhs[r][c] = pick_value(VAL_SMALL);
        for (int c = 0; c < LANES; c++)
            send_vector(mk_vec(rhs[0][c], rhs[1][c], rhs[2][c], rhs[3][c]));
        drain_results();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // vectors back to back, so the pipeline fills and has to hold off its input.
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        load_matrix(VAL_MIXED);
        hold_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
            send_vector(random_vec());
        drain_results();
    endtask

    // The bulk of the run: a fresh matrix for every phase, each phase with its
    // own pacing on both sides. The first phase runs with no idling at all, and
    // the early phases force the small, the extreme and the full matrix families.
    task automatic test_random_phases();
        val_kind_e kind;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       kind = VAL_SMALL;
                1:       kind = VAL_EXTREME;
                2:       kind = VAL_FULL;
                default: kind = val_kind_e'($urandom_range(0, 3));
            endcase
            load_matrix(kind);
            if (p == 0) begin
                tx_gaps = 1'b0;
                rx_mode = RX_ALWAYS;
            end else begin
                tx_gaps = $urandom_range(0, 3) != 0;
                rx_mode = rx_mode_e'($urandom_range(0, 2));
            end
            burst_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_vector(random_vec());
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Ready changes at the falling edge. A requested hold-off is counted down
    // here and overrides whatever pacing mode is active.
    initial begin : result_sink
        logic [15:0] pattern;
        pattern   = 16'b1011_0011_1000_1101;
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            pattern = {pattern[14:0], pattern[15]};
            if (hold_left > 0) begin
                res_ready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_RANDOM:  res_ready <= $urandom_range(0, 3) != 0;
                    RX_PATTERN: res_ready <= pattern[0];
                    default:    res_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Every result transfer is compared with the oldest prediction.
    always @(posedge clk) begin : result_check
        out_item_t want;
        if (rst_n && res_valid && res_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no vector outstanding, actual %h", $time, res_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_x", want.out_x, res_data.out_x);
                check_field("out_y", want.out_y, res_data.out_y);
                check_field("out_z", want.out_z, res_data.out_z);
                check_field("out_w", want.out_w, res_data.out_w);
                check_field("saturated", want.saturated, res_data.saturated);
            end
        end
    end

    // Any transfer on any channel counts as progress; a long silence is a hang.
    always @(posedge clk) begin
        if ((vec_valid && vec_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        vec_valid = 1'b0;
        vec_data  = '0;
        load_identity_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_identity();
        test_register_map();
        test_saturation();
        test_matrix_product();
        test_backpressure();
        test_random_phases();

        // Everything predicted has arrived; keep clocking the pipeline so that a
        // spurious extra result would still be caught before the run ends.
        drain_results();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
